// ===== sv/keyed_record_table_defines.svh =====
// assertion macros used by the checker file
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/krt_pkg.sv =====
// types and constants of the keyed record table
package krt_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_LIST   = 3'd1,
        OP_SEARCH = 3'd2,
        OP_UPDATE = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_INVALID   = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] record_key;
        logic [63:0]        name_word;
        logic [15:0]        mark_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_key;
        logic [63:0]        found_name;
        logic [15:0]        found_mark;
        logic               last_item;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name;
        logic [15:0]        mark;
    } rec_t;

endpackage

// ===== sv/keyed_record_table.sv =====
// keyed record table: one record memory walked by a small sequencer
//
// Usage: each input transaction on in_valid/in_ready carries one command
// (add, list, search, update, delete). Results leave on out_valid/out_ready
// through an output register; last_item marks the final result of a command.
// One command is in work at a time; in_ready is high only between commands.
// Add, an invalid opcode and any command on an empty table go straight to the
// result. Search, update and delete scan the records up to the first match or
// the last record; a delete hit before the last record then shifts the later
// records down. List reads and sends the records in order while the receiver
// keeps up.
// The single read port of the record memory is walked one entry per cycle by
// the scan and the shift. The next command is taken only after the final
// result is registered.
// Reset clears the record count; memory contents are never cleared and entries
// at or beyond the count are never read.
// When the receiver stalls, the pending result holds in the output register
// and the sequencer waits in place; list resumes without losing a record.
module keyed_record_table
    import krt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_LIST  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    rec_t rec_mem [DEPTH];
    rec_t rd_rec_reg;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [2:0]         resp_status_reg, resp_status_next;
    logic               use_mem_reg, use_mem_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [63:0]        name_reg;
    logic [15:0]        mark_reg;

    logic               in_fire;
    logic               out_free;
    logic               out_load;
    logic               chk_last;
    logic               key_hit;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    rec_t               wr_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

    // entry held in rd_rec_reg is the last stored one
    assign chk_last = (CNT_W'(chk_idx_reg) + CNT_W'(1)) == count_reg;
    assign key_hit  = chk_vld_reg && (rd_rec_reg.key == key_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        chk_idx_next     = chk_idx_reg;
        chk_vld_next     = chk_vld_reg;
        resp_status_next = resp_status_reg;
        use_mem_next     = use_mem_reg;
        out_data_next    = out_data_reg;
        out_load         = 1'b0;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    use_mem_next = 1'b0;
                    rd_idx_next  = '0;
                    chk_vld_next = 1'b0;
                    case (in_item.opcode)
                        OP_ADD:
                        begin
                            state_next = S_RESP;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                resp_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = count_reg[IDX_W-1:0];
                                wr_data.key      = in_item.record_key;
                                wr_data.name     = in_item.name_word;
                                wr_data.mark     = in_item.mark_value;
                                count_next       = count_reg + CNT_W'(1);
                                resp_status_next = ST_OK;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_status_next = ST_EMPTY;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        OP_SEARCH, OP_UPDATE, OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_status_next = ST_NOT_FOUND;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            resp_status_next = ST_INVALID;
                            state_next       = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (key_hit)
                begin
                    resp_status_next = ST_OK;
                    state_next       = S_RESP;
                    case (op_reg)
                        OP_SEARCH:
                        begin
                            use_mem_next = 1'b1;
                        end
                        OP_UPDATE:
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = chk_idx_reg;
                            wr_data.key  = key_reg;
                            wr_data.name = name_reg;
                            wr_data.mark = mark_reg;
                        end
                        default:
                        begin
                            // delete: last entry goes without a shift
                            if (chk_last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                state_next   = S_SHIFT;
                                rd_idx_next  = CNT_W'(chk_idx_reg) + CNT_W'(1);
                                chk_vld_next = 1'b0;
                            end
                        end
                    endcase
                end
                else if (chk_vld_reg && chk_last)
                begin
                    resp_status_next = ST_NOT_FOUND;
                    state_next       = S_RESP;
                end
                else
                begin
                    rd_en        = rd_idx_reg < count_reg;
                    chk_vld_next = rd_en;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    if (rd_en)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                if (chk_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_idx_reg - IDX_W'(1);
                    wr_data = rd_rec_reg;
                end
                if (chk_vld_reg && chk_last)
                begin
                    count_next       = count_reg - CNT_W'(1);
                    resp_status_next = ST_OK;
                    state_next       = S_RESP;
                end
                else
                begin
                    rd_en        = rd_idx_reg < count_reg;
                    chk_vld_next = rd_en;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    if (rd_en)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end

            S_LIST:
            begin
                if (chk_vld_reg && out_free)
                begin
                    out_load                 = 1'b1;
                    out_data_next.status     = ST_OK;
                    out_data_next.found_key  = rd_rec_reg.key;
                    out_data_next.found_name = rd_rec_reg.name;
                    out_data_next.found_mark = rd_rec_reg.mark;
                    out_data_next.last_item  = chk_last;
                    chk_vld_next             = 1'b0;
                    if (chk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                // read data holds until the record has been sent
                rd_en = (rd_idx_reg < count_reg) && (!chk_vld_reg || out_load);
                if (rd_en)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_data_next        = '0;
                    out_data_next.status = resp_status_reg;
                    if (use_mem_reg)
                    begin
                        out_data_next.found_key  = rd_rec_reg.key;
                        out_data_next.found_name = rd_rec_reg.name;
                        out_data_next.found_mark = rd_rec_reg.mark;
                    end
                    out_data_next.last_item = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            rd_idx_reg      <= '0;
            chk_idx_reg     <= '0;
            chk_vld_reg     <= 1'b0;
            resp_status_reg <= ST_OK;
            use_mem_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            rd_idx_reg      <= rd_idx_next;
            chk_idx_reg     <= chk_idx_next;
            chk_vld_reg     <= chk_vld_next;
            resp_status_reg <= resp_status_next;
            use_mem_reg     <= use_mem_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // command payload and output data need no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= in_item.opcode;
            key_reg  <= in_item.record_key;
            name_reg <= in_item.name_word;
            mark_reg <= in_item.mark_value;
        end
        out_data_reg <= out_data_next;
    end

    // record memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_rec_reg <= rec_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

// ===== sv/krt_checker.sv =====
// port-level checks on the keyed record table, bound to the top level
`include "keyed_record_table_defines.svh"

module krt_checker
    import krt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    `KRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

    `KRT_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready, "second command taken while one is in work")

    `KRT_ASSERT_SAME(a_mid_list_ok, out_valid && !out_item.last_item, out_item.status == ST_OK, "non-final result without ok status")

    `KRT_ASSERT_SAME(a_mid_list_busy, out_valid && !out_item.last_item, !in_ready, "ready while a list is still being sent")

    `KRT_ASSERT_SAME(a_zero_fields, out_valid && out_item.status != ST_OK, out_item.found_key == 0 && out_item.found_name == 0 && out_item.found_mark == 0, "record fields set on a failed transaction")

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);
